### rtl/baro_pkg.sv
// ----------------------------------------------------------------------------
// baro_pkg
// Shared types, constants and coefficient functions of the altitude converter.
// ----------------------------------------------------------------------------
`default_nettype none

package baro_pkg;

  localparam int STEPS = 28;

  localparam logic [1:0]  REG_PB = 2'd0;
  localparam logic [1:0]  REG_TB = 2'd1;

  localparam logic [20:0] PB_RESET = 21'd1621200;
  localparam logic [14:0] TB_RESET = 15'd1500;

  localparam logic [21:0] EXP_Q24  = 22'd3192142;
  localparam logic [28:0] RECIP13  = 29'd330382099;
  localparam logic [26:0] T_CLAMP  = 27'd130000013;
  localparam logic signed [24:0] ALT_MAX = 25'sd10000000;
  localparam logic signed [24:0] ALT_MIN = -25'sd1000000;

  typedef struct packed {
    logic [30:0] m;
    logic [4:0]  msb;
    logic [27:0] frac;
  } log_lane_t;

  typedef struct packed {
    logic [30:0]       r;
    logic [27:0]       f;
    logic signed [4:0] n;
  } exp_lane_t;

  typedef struct packed {
    logic        ok;
    logic [26:0] k2;
  } side_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] r;
    logic [63:0] b;
    rem = v;
    r   = 64'd0;
    b   = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(2^-k) in Q30
  function automatic logic [30:0] exp_coef(input int k);
    logic [63:0] c;
    c = 64'd2 << 30;
    for (int j = 1; j <= k; j++) begin
      c = isqrt64(c << 30);
    end
    return c[30:0];
  endfunction

  function automatic log_lane_t log_step(input log_lane_t a);
    logic [61:0] sq;
    log_lane_t   o;
    sq    = {31'd0, a.m} * {31'd0, a.m};
    o.msb = a.msb;
    if (sq[61]) begin
      o.m    = sq[61:31];
      o.frac = {a.frac[26:0], 1'b1};
    end else begin
      o.m    = sq[60:30];
      o.frac = {a.frac[26:0], 1'b0};
    end
    return o;
  endfunction

endpackage

`default_nettype wire

### rtl/baro_log_cell.sv
// ----------------------------------------------------------------------------
// baro_log_cell
// One squaring step of the log2 fraction, for the sample and baseline lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_log_cell (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  adv,
  input  wire                  in_valid,
  input  baro_pkg::side_t      in_side,
  input  baro_pkg::log_lane_t  in_a,
  input  baro_pkg::log_lane_t  in_b,
  output logic                 out_valid,
  output baro_pkg::side_t      out_side,
  output baro_pkg::log_lane_t  out_a,
  output baro_pkg::log_lane_t  out_b
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_side <= in_side;
      out_a    <= baro_pkg::log_step(in_a);
      out_b    <= baro_pkg::log_step(in_b);
    end
  end

endmodule

`default_nettype wire

### rtl/baro_exp_cell.sv
// ----------------------------------------------------------------------------
// baro_exp_cell
// One factor of the exp2 product, applied when its fraction bit is set.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_exp_cell (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  adv,
  input  wire [30:0]           coef,
  input  wire                  in_valid,
  input  baro_pkg::side_t      in_side,
  input  baro_pkg::exp_lane_t  in_e,
  output logic                 out_valid,
  output baro_pkg::side_t      out_side,
  output baro_pkg::exp_lane_t  out_e
);

  logic [61:0] prod;

  assign prod = {31'd0, in_e.r} * {31'd0, coef};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_side <= in_side;
      out_e.n  <= in_e.n;
      out_e.f  <= {in_e.f[26:0], 1'b0};
      out_e.r  <= in_e.f[27] ? prod[60:30] : in_e.r;
    end
  end

endmodule

`default_nettype wire

### rtl/barometric_altitude.sv
// ----------------------------------------------------------------------------
// barometric_altitude
// Pressure sample to altitude above a configured baseline, fully pipelined.
// ----------------------------------------------------------------------------
// Input items arrive on s_t* (pressure in 1/16 Pa in tdata, reading-ok flag
// in tuser); one result item per input leaves on m_t* (altitude in cm in
// tdata, valid flag in tuser). The cfg channel writes the baseline pressure
// (index 0) and baseline temperature in 0.01 C (index 1); it is always ready.
// Throughput is one item per cycle unless stalled. Stages: an input register,
// 28 log2 squaring cells, two delta/exponent stages, 28 exp2 factor cells,
// and six stages for shift, scaling, divide by 13 and saturation.
// The whole pipeline advances together; when m_tready is low with a result
// waiting, every stage holds and s_tready drops in the same cycle.
// Reset empties the pipeline and restores both baseline registers.
// ----------------------------------------------------------------------------
`default_nettype none

module barometric_altitude (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [23:0] s_tdata,   // [20:0] pressure_sixteenths
  input  wire  [0:0]  s_tuser,   // [0] reading_valid
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,   // [24:0] height_cm
  output logic [0:0]  m_tuser,   // [0] altitude_valid
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [20:0] cfg_data
);

  localparam int N = baro_pkg::STEPS;

  logic        adv;
  logic [20:0] baseline_pressure;
  logic [14:0] baseline_temp_centi;

  assign adv       = !m_tvalid || m_tready;
  assign s_tready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_pressure   <= baro_pkg::PB_RESET;
      baseline_temp_centi <= baro_pkg::TB_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        baro_pkg::REG_PB: baseline_pressure   <= cfg_data;
        baro_pkg::REG_TB: baseline_temp_centi <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // input stage
  logic [20:0]         p_in;
  logic [4:0]          msb_p, msb_b;
  logic signed [16:0]  tsum;
  baro_pkg::log_lane_t a0, b0;
  baro_pkg::side_t     side0;

  assign p_in = s_tdata[20:0];

  always_comb begin
    msb_p = 5'd0;
    msb_b = 5'd0;
    for (int i = 1; i < 21; i++) begin
      if (p_in[i])              msb_p = 5'(i);
      if (baseline_pressure[i]) msb_b = 5'(i);
    end
    tsum     = {{2{baseline_temp_centi[14]}}, baseline_temp_centi} + 17'sd27315;
    a0.m     = 31'({10'd0, p_in} << (5'd30 - msb_p));
    a0.msb   = msb_p;
    a0.frac  = 28'd0;
    b0.m     = 31'({10'd0, baseline_pressure} << (5'd30 - msb_b));
    b0.msb   = msb_b;
    b0.frac  = 28'd0;
    side0.ok = s_tuser[0] && (p_in != 21'd0) && (baseline_pressure != 21'd0);
    side0.k2 = 27'(tsum[15:0]) * 27'd2000;
  end

  logic                lv [0:N];
  baro_pkg::side_t     ls [0:N];
  baro_pkg::log_lane_t la [0:N];
  baro_pkg::log_lane_t lb [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      lv[0] <= 1'b0;
    end else if (adv) begin
      lv[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ls[0] <= side0;
      la[0] <= a0;
      lb[0] <= b0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_log
    baro_log_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (lv[i]),
      .in_side   (ls[i]),
      .in_a      (la[i]),
      .in_b      (lb[i]),
      .out_valid (lv[i+1]),
      .out_side  (ls[i+1]),
      .out_a     (la[i+1]),
      .out_b     (lb[i+1])
    );
  end

  // log difference
  logic signed [34:0] d;
  logic               d1_valid;
  baro_pkg::side_t    d1_side;
  logic               d1_neg;
  logic [32:0]        d1_abs;

  assign d = $signed({2'b00, la[N].msb, la[N].frac}) - $signed({2'b00, lb[N].msb, lb[N].frac});

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_valid <= 1'b0;
    end else if (adv) begin
      d1_valid <= lv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_side <= ls[N];
      d1_neg  <= (d > 35'sd0);
      d1_abs  <= d[34] ? 33'(-d) : d[32:0];
    end
  end

  // exponent scaling
  logic [54:0]         ymul;
  logic [31:0]         ymag;
  logic signed [32:0]  y;
  baro_pkg::exp_lane_t e0;

  always_comb begin
    ymul  = 55'(d1_abs) * 55'(baro_pkg::EXP_Q24);
    ymag  = 32'((ymul + 55'(24'h800000)) >> 24);
    y     = d1_neg ? -$signed({1'b0, ymag}) : $signed({1'b0, ymag});
    e0.r  = 31'd1 << 30;
    e0.f  = y[27:0];
    e0.n  = y[32:28];
  end

  logic                ev [0:N];
  baro_pkg::side_t     es [0:N];
  baro_pkg::exp_lane_t ee [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      ev[0] <= 1'b0;
    end else if (adv) begin
      ev[0] <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      es[0] <= d1_side;
      ee[0] <= e0;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_exp
    localparam logic [30:0] COEF = baro_pkg::exp_coef(k + 1);
    baro_exp_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .coef      (COEF),
      .in_valid  (ev[k]),
      .in_side   (es[k]),
      .in_e      (ee[k]),
      .out_valid (ev[k+1]),
      .out_side  (es[k+1]),
      .out_e     (ee[k+1])
    );
  end

  // integer shift and ratio minus one
  logic [35:0]        rsh;
  logic [2:0]         rsa;
  logic signed [36:0] rm1;
  logic               r_valid, r_neg;
  baro_pkg::side_t    r_side;
  logic [34:0]        r_abs;

  always_comb begin
    rsa = 3'd0;
    if (!ee[N].n[4]) begin
      rsh = {5'd0, ee[N].r} << ee[N].n[3:0];
    end else begin
      rsa = 3'(-ee[N].n);
      rsh = ({5'd0, ee[N].r} + (36'd1 << (rsa - 3'd1))) >> rsa;
    end
    rm1 = $signed({1'b0, rsh}) - 37'sd1073741824;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (adv) begin
      r_valid <= ev[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_side <= es[N];
      r_neg  <= rm1[36];
      r_abs  <= rm1[36] ? 35'(-rm1) : rm1[34:0];
    end
  end

  // partial products
  logic            p_valid, p_neg;
  logic            p_ok;
  logic [43:0]     p_hi;
  logic [44:0]     p_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_ok  <= r_side.ok;
      p_neg <= r_neg;
      p_hi  <= 44'(r_side.k2) * 44'(r_abs[34:18]);
      p_lo  <= 45'(r_side.k2) * 45'(r_abs[17:0]);
    end
  end

  // drop Q30 with rounding, clamp
  logic [62:0] mag;
  logic [32:0] t;
  logic        t_valid, t_neg, t_ok;
  logic [26:0] t_c;

  assign mag = {1'b0, p_hi, 18'd0} + 63'(p_lo) + (63'd13 << 29);
  assign t   = mag[62:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
    end else if (adv) begin
      t_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_ok  <= p_ok;
      t_neg <= p_neg;
      t_c   <= (t >= 33'(baro_pkg::T_CLAMP)) ? baro_pkg::T_CLAMP : t[26:0];
    end
  end

  // divide by 13: reciprocal estimate
  logic        q_valid, q_neg, q_ok;
  logic [26:0] q_t;
  logic [55:0] q_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (adv) begin
      q_valid <= t_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_ok   <= t_ok;
      q_neg  <= t_neg;
      q_t    <= t_c;
      q_prod <= 56'(t_c) * 56'(baro_pkg::RECIP13);
    end
  end

  // correct the quotient
  logic [23:0] q0;
  logic [26:0] rem;
  logic        c_valid, c_neg, c_ok;
  logic [23:0] c_q;

  assign q0  = q_prod[55:32];
  assign rem = q_t - 27'(q0) * 27'd13;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_ok  <= q_ok;
      c_neg <= q_neg;
      c_q   <= (rem >= 27'd13) ? q0 + 24'd1 : q0;
    end
  end

  // sign, saturate, output register
  logic signed [24:0] alt;
  logic signed [24:0] alt_sat;

  always_comb begin
    alt = c_neg ? -$signed({1'b0, c_q}) : $signed({1'b0, c_q});
    if (alt > baro_pkg::ALT_MAX) begin
      alt_sat = baro_pkg::ALT_MAX;
    end else if (alt < baro_pkg::ALT_MIN) begin
      alt_sat = baro_pkg::ALT_MIN;
    end else begin
      alt_sat = alt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata    <= {7'd0, c_ok ? alt_sat : 25'sd0};
      m_tuser[0] <= c_ok;
    end
  end

  a_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[24:0]) <= baro_pkg::ALT_MAX &&
                  $signed(m_tdata[24:0]) >= baro_pkg::ALT_MIN))
    else $error("altitude out of range");

  a_invalid_zero : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == 32'd0))
    else $error("invalid item carries nonzero altitude");

  a_reset_empty : assert property (@(posedge clk)
    $past(rst) |-> (!m_tvalid && !c_valid && !lv[0]))
    else $error("pipeline not empty after reset");

  a_stall_ready : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(c_valid) && $stable(c_q))
    else $error("pipeline moved while stalled");

endmodule

`default_nettype wire
